// ===== rtl/stereo_modulated_feedback_delay_defines.svh =====
// Assertion macros for the file that carries checks.
// Each macro takes a label, a condition, a consequence and a message.
`ifndef STEREO_MODULATED_FEEDBACK_DELAY_DEFINES_SVH
`define STEREO_MODULATED_FEEDBACK_DELAY_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define SMFD_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define SMFD_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smfd_pkg.sv =====
`default_nettype none
package smfd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 14;
    localparam int LEN_W      = 15;
    localparam int GAIN_W     = 15;
    localparam int PHASE_W    = 16;
    localparam int EFF_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_LENGTH    = 3'd0,
        REG_RING_LENGTH     = 3'd1,
        REG_FEEDBACK_GAIN   = 3'd2,
        REG_WET_GAIN        = 3'd3,
        REG_LFO_DEPTH       = 3'd4,
        REG_LFO_INCREMENT   = 3'd5,
        REG_LFO_START_PHASE = 3'd6,
        REG_INPUT_MODULATES = 3'd7
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [DELAY_W-1:0]  DELAY_RST       = 14'd2400;
    localparam logic [LEN_W-1:0]    RING_LEN_RST    = 15'd2401;
    localparam logic [GAIN_W-1:0]   FEEDBACK_RST    = 15'd6144;
    localparam logic [GAIN_W-1:0]   WET_RST         = 15'd16384;
    localparam logic [PHASE_W-1:0]  DEPTH_RST       = 16'd0;
    localparam logic [PHASE_W-1:0]  INCREMENT_RST   = 16'd14;
    localparam logic [PHASE_W-1:0]  START_PHASE_RST = 16'd0;

    // Quarter-wave sine polynomial coefficients, Q14.
    localparam logic [14:0] SIN_QUARTER = 15'd16384;
    localparam logic [13:0] SIN_C_INNER = 14'd10512;
    localparam logic [10:0] SIN_C_CUBE  = 11'd1160;
    localparam logic [14:0] SIN_C_OUTER = 15'd25736;
    // One radian in phase units, for the input-driven phase step.
    localparam logic signed [31:0] RAD_TO_PHASE = 32'sd10430;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_MOD,
        BK_WRITE
    } back_state_t;

    typedef enum logic [2:0] {
        LF_IDLE,
        LF_T2,
        LF_INNER,
        LF_OUTER,
        LF_SINE,
        LF_FACTOR,
        LF_EFF
    } lfo_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       right;
    } fq_item_t;

    typedef struct packed {
        logic               advance;
        logic [PHASE_W-1:0] step;
    } lfo_cmd_t;

    typedef struct packed {
        logic             valid;
        logic [EFF_W-1:0] eff;
    } lfo_stat_t;

    typedef struct packed {
        logic clearing;
        logic start;
    } back_stat_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [18:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 19'sd32767)
            r = 16'sh7FFF;
        else if (v < -19'sd32768)
            r = 16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/smfd_front.sv =====
`default_nettype none
module smfd_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire logic signed [smfd_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                    full,
    input  wire logic                               hold,
    input  wire logic                               q_pop,
    output logic                                    q_valid,
    output smfd_pkg::fq_item_t                      q_head
);
    import smfd_pkg::*;

    fq_item_t   ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg, right_reg;
    logic [1:0] count_reg;
    logic       accept, take;

    // The front tags each beat with its channel; left comes first.
    assign full    = (count_reg == 2'd2) || hold;
    assign accept  = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign take    = q_pop && q_valid;
    assign q_head  = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            right_reg  <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
                right_reg  <= !right_reg;
            end
            if (take)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, accept} - {1'b0, take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_reg[wr_ptr_reg].sample <= sample_in;
            ent_reg[wr_ptr_reg].right  <= right_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smfd_lfo.sv =====
`default_nettype none
module smfd_lfo #(
    parameter int SINE_ENTRIES = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [smfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [smfd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [smfd_pkg::DELAY_W-1:0]         delay_length,
    input  wire logic [smfd_pkg::PHASE_W-1:0]         lfo_depth,
    input  wire smfd_pkg::lfo_cmd_t                   cmd,
    output smfd_pkg::lfo_stat_t                       st
);
    import smfd_pkg::*;

    // The phase is quantised to the sine table resolution by masking low bits.
    localparam int QSH = PHASE_W - $clog2(SINE_ENTRIES);
    localparam logic [PHASE_W-1:0] PMASK = PHASE_W'(17'h10000 - (17'd1 << QSH));

    lfo_state_t          state_reg, state_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                valid_reg, valid_next;
    logic [14:0]         t_reg, t2_reg, outer_reg;
    logic [13:0]         inner_reg;
    logic [1:0]          quad_reg;
    logic signed [15:0]  s_reg;
    logic [31:0]         factor_reg;
    logic [EFF_W-1:0]    eff_reg;

    logic                restart;
    logic [PHASE_W-1:0]  pq;
    logic [14:0]         t0, t_c;
    logic [29:0]         m_t2;
    logic [25:0]         m_in;
    logic [28:0]         m_out;
    logic [29:0]         m_y;
    logic [16:0]         y17;
    logic [15:0]         y_c;
    logic signed [32:0]  m_f;
    logic signed [33:0]  f_sum;
    logic [45:0]         m_e;

    assign restart = cmd.advance || cfg_we;
    assign st.valid = valid_reg;
    assign st.eff   = eff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LF_T2;
            phase_reg <= START_PHASE_RST;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (restart)
        begin
            state_next = LF_T2;
            valid_next = 1'b0;
            if (cfg_we && (cfg_index == REG_LFO_START_PHASE))
                phase_next = cfg_data;
            else if (cmd.advance)
                phase_next = phase_reg + cmd.step;
        end
        else
        begin
            case (state_reg)
                LF_IDLE:   state_next = LF_IDLE;
                LF_T2:     state_next = LF_INNER;
                LF_INNER:  state_next = LF_OUTER;
                LF_OUTER:  state_next = LF_SINE;
                LF_SINE:   state_next = LF_FACTOR;
                LF_FACTOR: state_next = LF_EFF;
                LF_EFF:
                begin
                    state_next = LF_IDLE;
                    valid_next = 1'b1;
                end
                default:   state_next = LF_IDLE;
            endcase
        end
    end

    // One multiplication per step of the polynomial, each into a register.
    always_comb
    begin
        pq    = phase_reg & PMASK;
        t0    = {1'b0, pq[13:0]};
        t_c   = pq[14] ? (SIN_QUARTER - t0) : t0;
        m_t2  = 30'(t_c) * 30'(t_c);
        m_in  = 26'(t2_reg) * 26'(SIN_C_CUBE);
        m_out = 29'(t2_reg) * 29'(inner_reg);
        m_y   = 30'(t_reg) * 30'(outer_reg);
        y17   = {m_y[29:14], 1'b0};
        y_c   = (y17 > 17'd32767) ? 16'd32767 : y17[15:0];
        m_f   = $signed({1'b0, lfo_depth}) * s_reg;
        f_sum = (34'sd1 <<< 31) + 34'(m_f);
        m_e   = 46'(delay_length) * 46'(factor_reg);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LF_T2:
            begin
                t_reg    <= t_c;
                quad_reg <= pq[15:14];
                t2_reg   <= m_t2[28:14];
            end
            LF_INNER:  inner_reg  <= SIN_C_INNER - 14'(m_in[25:14]);
            LF_OUTER:  outer_reg  <= SIN_C_OUTER - m_out[28:14];
            LF_SINE:   s_reg      <= quad_reg[1] ? -$signed(y_c) : $signed(y_c);
            LF_FACTOR: factor_reg <= f_sum[31:0];
            LF_EFF:    eff_reg    <= m_e[45:31];
            default:   eff_reg    <= eff_reg;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/smfd_back.sv =====
`default_nettype none
module smfd_back #(
    parameter int RING_DEPTH = 16384
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_valid,
    input  wire smfd_pkg::fq_item_t                   q_head,
    output logic                                      q_pop,
    input  wire smfd_pkg::lfo_stat_t                  lfo_st,
    output smfd_pkg::lfo_cmd_t                        lfo_cmd,
    input  wire logic [smfd_pkg::LEN_W-1:0]           ring_length,
    input  wire logic [smfd_pkg::GAIN_W-1:0]          feedback_gain,
    input  wire logic [smfd_pkg::GAIN_W-1:0]          wet_gain,
    input  wire logic [smfd_pkg::PHASE_W-1:0]         lfo_increment,
    input  wire logic                                 input_modulates_phase,
    input  wire logic                                 pop,
    output logic                                      empty,
    output logic signed [smfd_pkg::SAMPLE_W-1:0]      sample_out,
    output smfd_pkg::back_stat_t                      bk_st
);
    import smfd_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int LW = AW + 1;
    localparam int SW = ((AW > EFF_W) ? AW : EFF_W) + 1;
    localparam int CW = $clog2(SW + 1);

    logic signed [SAMPLE_W-1:0] left_mem  [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] right_mem [RING_DEPTH];

    back_state_t                state_reg, state_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              clr_reg, clr_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] held_reg, held_next;
    logic [SW-1:0]              sum_reg, sum_next;
    logic [LW-1:0]              rem_reg, rem_next;
    logic signed [SAMPLE_W-1:0] x_reg, rd_l_reg, rd_r_reg;
    logic                       right_reg;
    logic signed [17:0]         wet_reg, fb_reg;
    logic signed [SAMPLE_W-1:0] out_mem_reg [2];
    logic                       out_wr_reg, out_rd_reg;
    logic [1:0]                 out_cnt_reg;

    logic [LW-1:0]              len_eff;
    logic                       start, out_push, out_take;
    logic                       we_l, we_r;
    logic [AW-1:0]              waddr;
    logic signed [SAMPLE_W-1:0] wdata, y_val, w_val, r_sel;
    logic [LW:0]                shifted;
    logic [LW-1:0]              pos_inc;
    logic signed [31:0]         wet_full, fb_full, step_prod;
    logic signed [16:0]         pair_sum;

    always_comb
    begin
        if (ring_length == '0)
            len_eff = LW'(1);
        else if (32'(ring_length) > 32'(RING_DEPTH))
            len_eff = LW'(RING_DEPTH);
        else
            len_eff = LW'(ring_length);
    end

    assign r_sel    = right_reg ? rd_r_reg : rd_l_reg;
    assign wet_full = $signed({1'b0, wet_gain}) * r_sel;
    assign fb_full  = $signed({1'b0, feedback_gain}) * r_sel;
    assign y_val    = sat16(19'(x_reg) + 19'(wet_reg));
    assign w_val    = sat16(19'(x_reg) + 19'(fb_reg));
    assign shifted  = {rem_reg, sum_reg[SW-1]};
    assign pos_inc  = {1'b0, pos_reg} + LW'(1);
    assign pair_sum = 17'(held_reg) + 17'(x_reg);
    assign step_prod = 32'(pair_sum) * RAD_TO_PHASE;

    assign start    = (state_reg == BK_IDLE) && q_valid && lfo_st.valid
                      && (out_cnt_reg != 2'd2);
    assign q_pop    = start;
    assign out_push = (state_reg == BK_WRITE);
    assign empty    = (out_cnt_reg == 2'd0);
    assign out_take = pop && !empty;
    assign sample_out = out_mem_reg[out_rd_reg];
    assign bk_st.clearing = (state_reg == BK_CLEAR);
    assign bk_st.start    = start;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        held_next  = held_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        we_l       = 1'b0;
        we_r       = 1'b0;
        waddr      = clr_reg;
        wdata      = '0;
        lfo_cmd.advance = 1'b0;
        lfo_cmd.step    = input_modulates_phase ? step_prod[31:16] : lfo_increment;
        case (state_reg)
            BK_CLEAR:
            begin
                we_l     = 1'b1;
                we_r     = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(RING_DEPTH - 1))
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (start)
                begin
                    sum_next   = SW'(pos_reg) + SW'(lfo_st.eff);
                    rem_next   = '0;
                    cnt_next   = CW'(SW);
                    state_next = BK_MOD;
                end
            end
            BK_MOD:
            begin
                // Restoring remainder, one bit of the write index sum a cycle.
                if (shifted >= {1'b0, len_eff})
                    rem_next = LW'(shifted - {1'b0, len_eff});
                else
                    rem_next = shifted[LW-1:0];
                sum_next = sum_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = BK_WRITE;
            end
            BK_WRITE:
            begin
                waddr = rem_reg[AW-1:0];
                wdata = w_val;
                we_l  = !right_reg;
                we_r  = right_reg;
                if (right_reg)
                begin
                    pos_next        = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];
                    lfo_cmd.advance = 1'b1;
                end
                else
                    held_next = x_reg;
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_CLEAR;
            pos_reg     <= '0;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            held_reg    <= '0;
            out_wr_reg  <= 1'b0;
            out_rd_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            held_reg    <= held_next;
            if (out_push)
                out_wr_reg <= !out_wr_reg;
            if (out_take)
                out_rd_reg <= !out_rd_reg;
            out_cnt_reg <= out_cnt_reg + {1'b0, out_push} - {1'b0, out_take};
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        wet_reg <= wet_full[31:14];
        fb_reg  <= fb_full[31:14];
        if (start)
        begin
            x_reg     <= q_head.sample;
            right_reg <= q_head.right;
        end
        if (out_push)
            out_mem_reg[out_wr_reg] <= y_val;
    end

    always_ff @(posedge clk)
    begin
        if (we_l)
            left_mem[waddr] <= wdata;
        rd_l_reg <= left_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (we_r)
            right_mem[waddr] <= wdata;
        rd_r_reg <= right_mem[pos_reg];
    end

endmodule
`default_nettype wire

// ===== rtl/stereo_modulated_feedback_delay.sv =====
`default_nettype none
`include "stereo_modulated_feedback_delay_defines.svh"
// Stereo feedback delay with a sine LFO on the delay length. Samples arrive as
// queue beats, left then right, and each beat yields one output beat of the same
// channel: the input plus the wet gain times the delayed sample, saturated. After
// reset the block clears both rings, one entry of each per cycle, and holds full
// high until the clear is done before it takes the first beat. In the back end
// the write index sum (16 bits wide at the default ring depth) is reduced modulo
// the ring length one bit per cycle. After every right sample the LFO unit
// recomputes the effective delay (square, inner term, outer term, sine, factor,
// effective delay) before the next sample may start, as it does after any
// configuration write. Two input beats and two output beats can wait in the
// queues on either side, so the source and the sink may stall independently.
// Configuration registers are written by index; the user must write them only
// while the block is idle, which the block itself does not enforce. Writing the
// start phase also reloads the LFO phase.
module stereo_modulated_feedback_delay #(
    parameter int RING_DEPTH   = 16384,
    parameter int SINE_ENTRIES = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [smfd_pkg::SAMPLE_W-1:0]   sample_in,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [smfd_pkg::SAMPLE_W-1:0]        sample_out,
    input  wire logic                                   cfg_we,
    input  wire logic [smfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [smfd_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import smfd_pkg::*;

    // Configuration registers. The start phase lives in the LFO unit, which
    // loads it straight into its phase register when it is written.
    logic [DELAY_W-1:0] delay_length_reg;
    logic [LEN_W-1:0]   ring_length_reg;
    logic [GAIN_W-1:0]  feedback_gain_reg, wet_gain_reg;
    logic [PHASE_W-1:0] lfo_depth_reg, lfo_increment_reg;
    logic               input_mod_reg;

    logic               q_valid, q_pop;
    fq_item_t           q_head;
    lfo_cmd_t           lfo_cmd;
    lfo_stat_t          lfo_st;
    back_stat_t         bk_st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg    <= DELAY_RST;
            ring_length_reg     <= RING_LEN_RST;
            feedback_gain_reg   <= FEEDBACK_RST;
            wet_gain_reg        <= WET_RST;
            lfo_depth_reg       <= DEPTH_RST;
            lfo_increment_reg   <= INCREMENT_RST;
            input_mod_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELAY_LENGTH:    delay_length_reg    <= cfg_data[DELAY_W-1:0];
                REG_RING_LENGTH:     ring_length_reg     <= cfg_data[LEN_W-1:0];
                REG_FEEDBACK_GAIN:   feedback_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_WET_GAIN:        wet_gain_reg        <= cfg_data[GAIN_W-1:0];
                REG_LFO_DEPTH:       lfo_depth_reg       <= cfg_data;
                REG_LFO_INCREMENT:   lfo_increment_reg   <= cfg_data;
                // Taken by the LFO unit.
                REG_LFO_START_PHASE: ;
                REG_INPUT_MODULATES: input_mod_reg       <= cfg_data[0];
                default:             input_mod_reg       <= input_mod_reg;
            endcase
        end
    end

    // The front takes beats and tags the channel; it is held off while the
    // rings are being cleared.
    smfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample_in (sample_in),
        .full      (full),
        .hold      (bk_st.clearing),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_head    (q_head)
    );

    // The LFO unit keeps the phase and the effective delay it implies.
    smfd_lfo #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_lfo (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .delay_length (delay_length_reg),
        .lfo_depth    (lfo_depth_reg),
        .cmd          (lfo_cmd),
        .st           (lfo_st)
    );

    // The back end reads and writes the rings and queues the results.
    smfd_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .q_valid               (q_valid),
        .q_head                (q_head),
        .q_pop                 (q_pop),
        .lfo_st                (lfo_st),
        .lfo_cmd               (lfo_cmd),
        .ring_length           (ring_length_reg),
        .feedback_gain         (feedback_gain_reg),
        .wet_gain              (wet_gain_reg),
        .lfo_increment         (lfo_increment_reg),
        .input_modulates_phase (input_mod_reg),
        .pop                   (pop),
        .empty                 (empty),
        .sample_out            (sample_out),
        .bk_st                 (bk_st)
    );

    // A sample never starts on a stale effective delay.
    `SMFD_ASSERT_NOW(a_start_needs_delay, bk_st.start, lfo_st.valid, "sample started without a valid delay")
    // No beat is taken while the rings are still being cleared.
    `SMFD_ASSERT_NOW(a_full_while_clear, bk_st.clearing, full, "input open during ring clear")
    // A right sample always makes the LFO recompute before the next sample.
    `SMFD_ASSERT_NEXT(a_advance_drops_valid, lfo_cmd.advance, !lfo_st.valid, "delay kept valid after phase step")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Scoreboard for the stereo delay. It keeps its own copy of both rings, the
// read position, the channel toggle and the LFO phase, and works out the
// output sample for every input beat that the block accepts.
class delay_scoreboard;
    shortint          ring_mem[2][16384];
    int unsigned      rd_pos;
    bit               right_side;
    bit [15:0]        phase;
    int               held_left;
    int unsigned      delay_len, ring_len, fb_gain, wet_gain, depth, incr, start_ph;
    bit               input_mod;
    shortint          expected_out[$];
    int               failures;
    int               beats_in;
    int               beats_out;

    function new();
        foreach (ring_mem[c, i])
            ring_mem[c][i] = 0;
        rd_pos     = 0;
        right_side = 0;
        held_left  = 0;
        delay_len  = 2400;
        ring_len   = 2401;
        fb_gain    = 6144;
        wet_gain   = 16384;
        depth      = 0;
        incr       = 14;
        start_ph   = 0;
        input_mod  = 0;
        phase      = 0;
        failures   = 0;
        beats_in   = 0;
        beats_out  = 0;
    endfunction

    function void set_register(smfd_pkg::cfg_reg_t idx, bit [15:0] value);
        case (idx)
            smfd_pkg::REG_DELAY_LENGTH:    delay_len = value[13:0];
            smfd_pkg::REG_RING_LENGTH:     ring_len  = value[14:0];
            smfd_pkg::REG_FEEDBACK_GAIN:   fb_gain   = value[14:0];
            smfd_pkg::REG_WET_GAIN:        wet_gain  = value[14:0];
            smfd_pkg::REG_LFO_DEPTH:       depth     = value;
            smfd_pkg::REG_LFO_INCREMENT:   incr      = value;
            smfd_pkg::REG_LFO_START_PHASE:
            begin
                start_ph = value;
                phase    = value;
            end
            default:                       input_mod = value[0];
        endcase
    endfunction

    // Quarter-wave polynomial sine of the phase quantised to the table size.
    function int sine_of(bit [15:0] ph);
        longint unsigned idx, p, quad, t, t2, inner, outer, y;
        idx   = (longint'(ph) * 1024) >> 16;
        p     = ((idx * 65536) / 1024) & 16'hFFFF;
        quad  = p >> 14;
        t     = p & 14'h3FFF;
        if (quad[0])
            t = 16384 - t;
        t2    = (t * t) >> 14;
        inner = 10512 - ((t2 * 1160) >> 14);
        outer = 25736 - ((t2 * inner) >> 14);
        y     = ((t * outer) >> 14) << 1;
        if (y > 32767)
            y = 32767;
        return quad[1] ? -int'(y) : int'(y);
    endfunction

    function int clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    function void note_input(shortint sample);
        int          x, y, w;
        int unsigned len, pos;
        longint      factor, r, step;
        longint unsigned eff, widx;
        x   = sample;
        len = (ring_len == 0) ? 1 : ((ring_len > 16384) ? 16384 : ring_len);
        pos = rd_pos % 16384;
        factor = (longint'(1) << 31) + longint'(depth) * sine_of(phase);
        eff    = (longint'(delay_len) * factor) >> 31;
        r   = ring_mem[right_side][pos];
        y   = clamp16(x + ((longint'(wet_gain) * r) >>> 14));
        w   = clamp16(x + ((longint'(fb_gain) * r) >>> 14));
        widx = (pos + eff) % len;
        ring_mem[right_side][widx] = shortint'(w);
        if (right_side)
        begin
            pos++;
            rd_pos = (pos >= len) ? 0 : pos;
            if (input_mod)
                step = (longint'(held_left + x) * 10430) >>> 16;
            else
                step = incr;
            phase      = phase + step[15:0];
            right_side = 0;
        end
        else
        begin
            held_left  = x;
            right_side = 1;
        end
        expected_out.push_back(shortint'(y));
        beats_in++;
    endfunction

    function void check_output(shortint actual);
        shortint exp_val;
        beats_out++;
        if (expected_out.size() == 0)
        begin
            $error("sample_out: unexpected beat with value %0d", actual);
            failures++;
            return;
        end
        exp_val = expected_out.pop_front();
        if (exp_val !== actual)
        begin
            $error("sample_out mismatch: expected %0d, actual %0d", exp_val, actual);
            failures++;
        end
    endfunction

    function int waiting();
        return expected_out.size();
    endfunction
endclass

module testbench;
    import smfd_pkg::*;

    // Cycles without any accepted beat before the run is declared hung. Both
    // the ring clear after reset and the long receiver hold-off stay within
    // this limit.
    localparam int STALL_LIMIT = 60000;
    localparam int PHASE_BEATS = 160;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       empty;
    logic                       pop;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    delay_scoreboard delay_sb;
    bit              src_idle_on;
    bit              sink_idle_on;
    bit              hold_request;
    int              stall_cycles;
    int              cfg_phases;

    stereo_modulated_feedback_delay i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample_in  (sample_in),
        .empty      (empty),
        .pop        (pop),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Both handshakes are observed at the rising edge; every input moves on
    // the falling edge, so the sampled values are always settled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                delay_sb.note_input(sample_in);
            if (pop && !empty)
                delay_sb.check_output(sample_out);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver. A long hold-off is counted here, in cycles, once the main
    // sequence asks for it; otherwise pop idles in random bursts while sink idling is on.
    initial
    begin : sink_proc
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                hold_left    = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                pop <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                idle_left = $urandom_range(1, 14) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // One input beat. push stays high on return so that back-to-back beats
    // never lower and raise it within one time step.
    task automatic send_sample(shortint value);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push      <= 1'b1;
        sample_in <= value;
        do
            @(posedge clk);
        while (full);
    endtask

    // Random sample with extra weight on full scale and on zero.
    function automatic shortint random_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return shortint'($urandom_range(0, 3)) - 2;
            default: return shortint'($urandom_range(0, 65535));
        endcase
    endfunction

    // Lowers push and waits, checking at every falling edge, until every output is back.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (delay_sb.waiting() != 0)
            @(negedge clk);
    endtask

    // The block is idle only once every output has come back and the LFO unit
    // has finished the recompute that follows a right sample.
    task automatic settle();
        drain();
        repeat (40) @(negedge clk);
    endtask

    task automatic write_register(cfg_reg_t idx, bit [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        delay_sb.set_register(idx, value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_settings(bit [15:0] dly, bit [15:0] len, bit [15:0] fb,
                                 bit [15:0] wet, bit [15:0] dep, bit [15:0] inc,
                                 bit [15:0] ph, bit [15:0] modulate);
        settle();
        write_register(REG_DELAY_LENGTH, dly);
        write_register(REG_RING_LENGTH, len);
        write_register(REG_FEEDBACK_GAIN, fb);
        write_register(REG_WET_GAIN, wet);
        write_register(REG_LFO_DEPTH, dep);
        write_register(REG_LFO_INCREMENT, inc);
        write_register(REG_LFO_START_PHASE, ph);
        write_register(REG_INPUT_MODULATES, modulate);
        repeat (10) @(negedge clk);
        cfg_phases++;
    endtask

    task automatic random_burst(int beats);
        for (int i = 0; i < beats; i++)
            send_sample(random_sample());
    endtask

    initial
    begin
        delay_sb     = new();
        rst_n        = 1'b0;
        push         = 1'b0;
        sample_in    = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_DELAY_LENGTH;
        cfg_data     = '0;
        src_idle_on  = 1;
        sink_idle_on = 1;
        hold_request = 0;
        stall_cycles = 0;
        cfg_phases   = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // A few beats on the reset settings first; these also wait out the
        // ring clear, since full stays high until it is done.
        for (int i = 0; i < 4; i++)
            send_sample(random_sample());

        // Short ring, maximum gains: full-scale inputs must saturate both the
        // output and the feedback write once the first echoes come round.
        load_settings(3, 8, 32767, 32767, 0, 14, 0, 0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        for (int i = 0; i < 10; i++)
            send_sample(i[0] ? 16'sh8000 : 16'sh7FFF);
        send_sample(16'sh0001);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        random_burst(PHASE_BEATS - 19);

        // Full depth, sine swings across all quadrants. The receiver holds
        // off for a long stretch here while the sender keeps offering beats.
        load_settings(5, 16, 16384, 16384, 65535, 4096, 16384, 0);
        random_burst(30);
        hold_request = 1;
        random_burst(PHASE_BEATS - 30);

        // Largest delay and ring, input-driven phase, start phase at the top.
        // Part-way through the sender waits for every output to drain.
        load_settings(16383, 16384, 8000, 20000, 65535, 65535, 65535, 1);
        random_burst(80);
        drain();
        random_burst(PHASE_BEATS - 80);

        // Ring length of zero behaves as one, zero delay, no wet signal.
        load_settings(0, 0, 32767, 0, 12345, 1, 0, 1);
        random_burst(PHASE_BEATS);

        // Ring length beyond the memory is clipped to the memory depth.
        load_settings(10, 32767, 20000, 30000, 30000, 300, 40000, 1);
        random_burst(PHASE_BEATS);

        // Shrinking the ring leaves the read position beyond its end, which
        // must still be read once before it wraps back to zero.
        load_settings(2, 4, 0, 32767, 65535, 16384, 49152, 0);
        random_burst(PHASE_BEATS);

        load_settings(1, 1, 12000, 24000, 0, 0, 32768, 0);
        random_burst(PHASE_BEATS);

        // Last stretch runs flat out on both sides.
        load_settings(7, 23, 24576, 8192, 50000, 777, 12345, 1);
        src_idle_on  = 0;
        sink_idle_on = 0;
        random_burst(PHASE_BEATS);

        drain();
        repeat (60) @(posedge clk);

        $display("Run covered %0d input beats and %0d output beats over %0d register settings,",
                 delay_sb.beats_in, delay_sb.beats_out, cfg_phases);
        $display("including saturation, ring wrap limits, full LFO depth and input-driven phase.");
        if (delay_sb.failures == 0 && delay_sb.waiting() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
